// ===== sv/blm_pkg.sv =====
// Shared types and constants for the blink lamp motion decoder.
`default_nettype none

package blm_pkg;

   // Register field widths and the width of the reported half period
   localparam int OPEN_WIDTH    = 16;
   localparam int CLOSE_WIDTH   = 16;
   localparam int TIMEOUT_WIDTH = 20;
   localparam int CSR_WIDTH     = 20;
   localparam int HALF_WIDTH    = 20;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_OPENING_HALF = 2'd0;
   localparam logic [1:0] CSR_CLOSING_HALF = 2'd1;
   localparam logic [1:0] CSR_STOP_TIMEOUT = 2'd2;

   // Register reset values
   localparam logic [OPEN_WIDTH-1:0]    OPEN_RESET    = 16'd500;
   localparam logic [CLOSE_WIDTH-1:0]   CLOSE_RESET   = 16'd1000;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 20'd3000;

   // Depth of the event queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      HEADING_UNKNOWN = 2'd0,
      HEADING_OPEN    = 2'd1,
      HEADING_CLOSE   = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      KIND_NONSENSE = 2'd0,
      KIND_OPENING  = 2'd1,
      KIND_CLOSING  = 2'd2,
      KIND_STOPPED  = 2'd3
   } kind_type;

   // What the front found on one tick
   typedef enum logic [1:0] {
      EVT_REPEAT  = 2'd0,   // stable level equal to the current level
      EVT_START   = 2'd1,   // edge while stopped
      EVT_EDGE    = 2'd2,   // edge while moving, classified
      EVT_TIMEOUT = 2'd3    // no edge for the timeout span
   } evt_code_type;

   typedef struct packed {
      evt_code_type          code;
      kind_type              kind;
      logic                  level;
      logic [HALF_WIDTH-1:0] half;
   } evt_type;

endpackage

`default_nettype wire

// ===== sv/blm_front.sv =====
// Front end: config registers, debouncer, edge timer and half-period classifier.
`default_nettype none

module blm_front
   import blm_pkg::*;
#(
   parameter int DEBOUNCE_SAMPLES = 8,
   parameter int TICK_COUNT_WIDTH = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_sample_level,
   input  wire logic                 q_ready,
   output logic                      push,
   output evt_type                   push_evt
);

   localparam int TW = TICK_COUNT_WIDTH;
   localparam int DS = DEBOUNCE_SAMPLES;
   localparam int CW = (TW > TIMEOUT_WIDTH) ? TW : TIMEOUT_WIDTH;

   function automatic logic [DS-1:0] alt_pattern();
      logic [DS-1:0] p;
      for (int i = 0; i < DS; i++) begin
         p[i] = 1'(i % 2);
      end
      return p;
   endfunction

   localparam logic [DS-1:0] HIST_RESET = alt_pattern();

   // 10 * |t - nom| < nom
   function automatic logic near_nominal(input logic [CW-1:0] t, input logic [CW-1:0] nom);
      logic [CW-1:0] diff;
      logic [CW+3:0] d10;
      diff = (t > nom) ? (t - nom) : (nom - t);
      d10  = ({4'b0, diff} << 3) + ({4'b0, diff} << 1);
      return d10 < {4'b0, nom};
   endfunction

   logic [OPEN_WIDTH-1:0]    open_half_ff;
   logic [CLOSE_WIDTH-1:0]   close_half_ff;
   logic [TIMEOUT_WIDTH-1:0] timeout_ff;

   logic [DS-1:0] hist_ff, hist_in;
   logic          stable_known_ff, stable_known_in;
   logic          stable_level_ff, stable_level_in;
   logic          level_ff, level_in;
   logic          moving_ff, moving_in;
   logic          armed_ff, armed_in;
   logic [TW-1:0] ticks_ff, ticks_in;

   logic          accept;
   logic [TW-1:0] ticks_inc;
   logic          lvl_valid, lvl;
   logic [CW-1:0] t_ext;
   kind_type      kind;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         open_half_ff  <= OPEN_RESET;
         close_half_ff <= CLOSE_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OPENING_HALF: open_half_ff  <= csr_wdata[OPEN_WIDTH-1:0];
            CSR_CLOSING_HALF: close_half_ff <= csr_wdata[CLOSE_WIDTH-1:0];
            CSR_STOP_TIMEOUT: timeout_ff    <= csr_wdata[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = q_ready;
   assign accept    = req_valid & q_ready;

   // Saturating tick count and debounce window
   assign ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
   assign hist_in   = {hist_ff[DS-2:0], req_sample_level};
   assign lvl_valid = (hist_in == '1) || (hist_in == '0);
   assign lvl       = hist_in[0];
   assign t_ext     = CW'(ticks_inc);

   // Classify the level that just ended
   always_comb begin
      if (near_nominal(t_ext, CW'(open_half_ff)))
         kind = KIND_OPENING;
      else if (near_nominal(t_ext, CW'(close_half_ff)))
         kind = KIND_CLOSING;
      else if (t_ext > CW'(timeout_ff))
         kind = KIND_STOPPED;
      else
         kind = KIND_NONSENSE;
   end

   // Tick decision: edge, repeated level, timeout or nothing
   always_comb begin
      stable_known_in = stable_known_ff;
      stable_level_in = stable_level_ff;
      level_in        = level_ff;
      moving_in       = moving_ff;
      armed_in        = armed_ff;
      ticks_in        = ticks_inc;
      push            = 1'b0;
      push_evt.code   = EVT_REPEAT;
      push_evt.kind   = kind;
      push_evt.level  = lvl;
      push_evt.half   = HALF_WIDTH'(ticks_inc);
      if (lvl_valid && (!stable_known_ff || (lvl != stable_level_ff))) begin
         stable_known_in = 1'b1;
         stable_level_in = lvl;
         push            = accept;
         if (lvl == level_ff) begin
            push_evt.code = EVT_REPEAT;
         end else begin
            level_in  = lvl;
            ticks_in  = '0;
            armed_in  = 1'b1;
            moving_in = 1'b1;
            push_evt.code = moving_ff ? EVT_EDGE : EVT_START;
         end
      end else if (armed_ff && (t_ext >= CW'(timeout_ff))) begin
         armed_in       = 1'b0;
         moving_in      = 1'b0;
         push           = accept;
         push_evt.code  = EVT_TIMEOUT;
         push_evt.level = level_ff;
         push_evt.half  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff         <= HIST_RESET;
         stable_known_ff <= 1'b0;
         stable_level_ff <= 1'b0;
         level_ff        <= 1'b1;
         moving_ff       <= 1'b0;
         armed_ff        <= 1'b0;
         ticks_ff        <= '0;
      end else if (accept) begin
         hist_ff         <= hist_in;
         stable_known_ff <= stable_known_in;
         stable_level_ff <= stable_level_in;
         level_ff        <= level_in;
         moving_ff       <= moving_in;
         armed_ff        <= armed_in;
         ticks_ff        <= ticks_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/blm_queue.sv =====
// Short event queue between the front end and the back end.
`default_nettype none

module blm_queue
   import blm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  evt_type      push_evt,
   output logic         q_ready,
   input  wire logic    pop,
   output logic         head_valid,
   output evt_type      head_evt
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   evt_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_pop;

   assign q_ready    = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_evt   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== sv/blm_back.sv =====
// Back end: kind counts, majority vote, direction tracking and result register.
`default_nettype none

module blm_back
   import blm_pkg::*;
#(
   parameter int KIND_COUNT_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  evt_type                    head_evt,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_is_moving,
   output logic [1:0]                 rsp_direction,
   output logic                       rsp_contact_level,
   output logic [HALF_WIDTH-1:0]      rsp_half_period_ticks,
   output logic                       rsp_report_cause
);

   localparam int KW = KIND_COUNT_WIDTH;

   logic [KW-1:0] counts_ff [4];
   logic [KW-1:0] counts_in [4];
   logic [KW-1:0] total_ff, total_in;
   dir_type       dir_ff, dir_in;

   logic                  valid_ff;
   logic                  moving_ff, moving_in;
   logic                  level_ff;
   logic [HALF_WIDTH-1:0] half_ff;
   logic                  cause_ff, cause_in;

   logic          out_free;
   logic          emits;
   logic [KW-1:0] inc_counts [4];
   logic [KW-1:0] inc_total;
   logic [KW-1:0] best_n;
   kind_type      best;

   assign out_free = !valid_ff || rsp_ready;
   assign emits    = (head_evt.code != EVT_REPEAT);
   assign pop      = head_valid && (!emits || out_free);

   // Counts after a classified edge, and the strict-first argmax over them
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         inc_counts[i] = counts_ff[i];
         if ((2'(i) == head_evt.kind) && (counts_ff[i] != '1))
            inc_counts[i] = counts_ff[i] + 1'b1;
      end
      inc_total = (total_ff == '1) ? total_ff : total_ff + 1'b1;
      best   = KIND_NONSENSE;
      best_n = '0;
      for (int i = 0; i < 4; i++) begin
         if (inc_counts[i] > best_n) begin
            best_n = inc_counts[i];
            best   = kind_type'(2'(i));
         end
      end
   end

   // Apply the head word
   always_comb begin
      counts_in = counts_ff;
      total_in  = total_ff;
      dir_in    = dir_ff;
      moving_in = 1'b1;
      cause_in  = 1'b0;
      case (head_evt.code)
         EVT_REPEAT: begin
            if (dir_ff == HEADING_UNKNOWN)
               dir_in = head_evt.level ? HEADING_CLOSE : HEADING_OPEN;
         end
         EVT_START: begin
            for (int i = 0; i < 4; i++) counts_in[i] = '0;
            total_in = '0;
            case (dir_ff)
               HEADING_OPEN:  dir_in = HEADING_CLOSE;
               HEADING_CLOSE: dir_in = HEADING_OPEN;
               default:       dir_in = HEADING_UNKNOWN;
            endcase
         end
         EVT_EDGE: begin
            counts_in = inc_counts;
            total_in  = inc_total;
            if (((best == KIND_OPENING) || (best == KIND_CLOSING)) &&
                ({best_n, 1'b0} >= {1'b0, inc_total}))
               dir_in = (best == KIND_OPENING) ? HEADING_OPEN : HEADING_CLOSE;
         end
         EVT_TIMEOUT: begin
            moving_in = 1'b0;
            cause_in  = 1'b1;
            dir_in    = head_evt.level ? HEADING_CLOSE : HEADING_OPEN;
         end
         default: ;
      endcase
   end

   // Vote state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) counts_ff[i] <= '0;
         total_ff <= '0;
         dir_ff   <= HEADING_UNKNOWN;
      end else if (pop) begin
         counts_ff <= counts_in;
         total_ff  <= total_in;
         dir_ff    <= dir_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop && emits) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emits) begin
         moving_ff <= moving_in;
         level_ff  <= head_evt.level;
         half_ff   <= head_evt.half;
         cause_ff  <= cause_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_is_moving         = moving_ff;
   assign rsp_direction         = dir_ff;
   assign rsp_contact_level     = level_ff;
   assign rsp_half_period_ticks = half_ff;
   assign rsp_report_cause      = cause_ff;

   a_timeout_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cause_ff) |-> (!moving_ff && (half_ff == '0)))
      else $error("timeout word must report stopped with zero half period");

   a_edge_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !cause_ff) |-> moving_ff)
      else $error("edge word must report moving");

endmodule

`default_nettype wire

// ===== sv/blink_lamp_motion_decoder.sv =====
// Top level of the blink lamp motion decoder.
`default_nettype none

// Blink lamp motion decoder. Each req word is one sample tick of the raw lamp
// contact level; the block takes one word per clock cycle. The front end
// debounces the level, times each level and classifies the half period in the
// same cycle it accepts the tick, then drops an event into a four-entry queue.
// The back end retires one queued event per cycle into the kind counts, the
// majority vote and the direction, and loads the result register; an event
// with a result waits while the rsp port stalls. A result reaches rsp through
// a queue slot and the result register. The req side stalls only once the queue
// is full behind a stalled rsp port. Config registers must be written through
// the csr port only while no tick is in flight; the block does not enforce it.

module blink_lamp_motion_decoder
   import blm_pkg::*;
#(
   parameter int DEBOUNCE_SAMPLES = 8,
   parameter int TICK_COUNT_WIDTH = 20,
   parameter int KIND_COUNT_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_WIDTH-1:0]  csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_sample_level,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_is_moving,
   output logic [1:0]                 rsp_direction,
   output logic                       rsp_contact_level,
   output logic [HALF_WIDTH-1:0]      rsp_half_period_ticks,
   output logic                       rsp_report_cause
);

   logic    q_ready;
   logic    push;
   evt_type push_evt;
   logic    pop;
   logic    head_valid;
   evt_type head_evt;

   blm_front #(
      .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_level (req_sample_level),
      .q_ready          (q_ready),
      .push             (push),
      .push_evt         (push_evt)
   );

   blm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_evt   (push_evt),
      .q_ready    (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_evt   (head_evt)
   );

   blm_back #(
      .KIND_COUNT_WIDTH (KIND_COUNT_WIDTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (head_valid),
      .head_evt              (head_evt),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_is_moving         (rsp_is_moving),
      .rsp_direction         (rsp_direction),
      .rsp_contact_level     (rsp_contact_level),
      .rsp_half_period_ticks (rsp_half_period_ticks),
      .rsp_report_cause      (rsp_report_cause)
   );

endmodule

`default_nettype wire
